// ===== rtl/olpd_pkg.sv =====
// ----------------------------------------------------------------------------
// olpd_pkg
// Shared types and codes for the ordered list with push-front and delete.
// ----------------------------------------------------------------------------
`default_nettype none

package olpd_pkg;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

    // command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_PUSH,
        CMD_DELETE,
        CMD_ROTATE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                 cmd;
        logic signed [VALUE_W-1:0] operand;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/olpd_cell.sv =====
// ----------------------------------------------------------------------------
// olpd_cell
// One slot of the list: a value and a valid bit, moved toward the back on a
// push, toward the front on a delete or a rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module olpd_cell (
    input  wire                                       clk,
    input  wire                                       rst_n,
    input  olpd_pkg::cell_ctrl_t                      ctrl,
    input  wire logic signed [olpd_pkg::VALUE_W-1:0]  prev_value,
    input  wire                                       prev_valid,
    input  wire logic signed [olpd_pkg::VALUE_W-1:0]  next_value,
    input  wire                                       next_valid,
    input  wire logic signed [olpd_pkg::VALUE_W-1:0]  front_value,
    input  wire                                       match_in,
    output logic signed [olpd_pkg::VALUE_W-1:0]       value,
    output logic                                      valid,
    output logic                                      match_out
);

    logic signed [olpd_pkg::VALUE_W-1:0] value_reg;
    logic signed [olpd_pkg::VALUE_W-1:0] value_next;
    logic                                valid_reg;
    logic                                valid_next;
    logic                                own_match;

    assign own_match = valid_reg && (value_reg == ctrl.operand);
    // a hit in this slot or anywhere in front of it closes the gap through here
    assign match_out = match_in || own_match;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (ctrl.cmd)
            olpd_pkg::CMD_PUSH:
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
            olpd_pkg::CMD_DELETE:
            begin
                if (match_out)
                begin
                    value_next = next_value;
                    valid_next = next_valid;
                end
            end
            olpd_pkg::CMD_ROTATE:
            begin
                // tail slot wraps around to the front entry
                if (valid_reg)
                begin
                    value_next = next_valid ? next_value : front_value;
                end
            end
            default:
            begin
                value_next = value_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/ordered_list_push_front_delete.sv =====
// ----------------------------------------------------------------------------
// ordered_list_push_front_delete
// Bounded list of signed 32-bit values, newest first, held in a chain of
// cells; add to front, delete first match, list all entries.
// ----------------------------------------------------------------------------
// Add and delete each give one result. An add with room shifts the chain
// back by one slot; a delete that hits moves the cells from the match on
// forward by one slot, and a delete ripples its match through all LIST_DEPTH
// cells. A list gives one result per held entry (one on an empty list): while
// the output register is free the chain rotates by one slot per cycle and the
// front cell feeds the output register, so the entries come out front to back
// and the list is back in its original order when the run ends. A new item is
// taken only when no list run is in progress and the output register is free
// or being emptied in that cycle. Operation code 3 is taken and does nothing.
`default_nettype none

module ordered_list_push_front_delete #(
    parameter int LIST_DEPTH = 16
) (
    input  wire                                       clk,
    input  wire                                       rst_n,
    input  wire                                       in_valid,
    output logic                                      in_ready,
    input  wire logic [olpd_pkg::OP_W-1:0]            operation,
    input  wire logic signed [olpd_pkg::VALUE_W-1:0]  item_value,
    output logic                                      out_valid,
    input  wire                                       out_ready,
    output logic signed [olpd_pkg::VALUE_W-1:0]       result_value,
    output logic [olpd_pkg::STATUS_W-1:0]             status,
    output logic [olpd_pkg::COUNT_W-1:0]              entry_count,
    output logic                                      last_of_run
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int EW = (CW > olpd_pkg::COUNT_W) ? CW : olpd_pkg::COUNT_W;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t                               state_reg, state_next;
    logic [CW-1:0]                        held_count_reg, held_count_next;
    logic [CW-1:0]                        remain_reg, remain_next;
    logic                                 out_valid_reg, out_valid_next;
    logic signed [olpd_pkg::VALUE_W-1:0]  result_value_reg, result_value_next;
    logic [olpd_pkg::STATUS_W-1:0]        status_reg, status_next;
    logic [olpd_pkg::COUNT_W-1:0]         entry_count_reg, entry_count_next;
    logic                                 last_reg, last_next;

    olpd_pkg::cell_ctrl_t                 ctrl;
    logic signed [olpd_pkg::VALUE_W-1:0]  value_w [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]                valid_vec;
    logic [LIST_DEPTH-1:0]                match_vec;

    logic                                 out_free;
    logic                                 in_fire;
    logic                                 full;
    logic                                 hit_any;
    logic [EW-1:0]                        count_ext;

    // ------------------------------------------------------------------
    // cell chain
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++)
        begin : g_cell
            logic signed [olpd_pkg::VALUE_W-1:0] prev_value;
            logic                                prev_valid;
            logic signed [olpd_pkg::VALUE_W-1:0] next_value;
            logic                                next_valid;
            logic                                match_in;

            if (gi == 0)
            begin : g_front
                assign prev_value = item_value;
                assign prev_valid = 1'b1;
                assign match_in   = 1'b0;
            end
            else
            begin : g_mid
                assign prev_value = value_w[gi-1];
                assign prev_valid = valid_vec[gi-1];
                assign match_in   = match_vec[gi-1];
            end

            if (gi == LIST_DEPTH - 1)
            begin : g_back
                assign next_value = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_inner
                assign next_value = value_w[gi+1];
                assign next_valid = valid_vec[gi+1];
            end

            olpd_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .prev_value  (prev_value),
                .prev_valid  (prev_valid),
                .next_value  (next_value),
                .next_valid  (next_valid),
                .front_value (value_w[0]),
                .match_in    (match_in),
                .value       (value_w[gi]),
                .valid       (valid_vec[gi]),
                .match_out   (match_vec[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;
    assign full     = (held_count_reg == CW'(LIST_DEPTH));
    assign hit_any  = match_vec[LIST_DEPTH-1];
    assign count_ext = EW'(held_count_next);

    always_comb
    begin
        state_next        = state_reg;
        held_count_next   = held_count_reg;
        remain_next       = remain_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        result_value_next = result_value_reg;
        status_next       = status_reg;
        last_next         = last_reg;
        ctrl.cmd          = olpd_pkg::CMD_HOLD;
        ctrl.operand      = item_value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    result_value_next = '0;
                    last_next         = 1'b1;
                    case (operation)
                        olpd_pkg::OP_ADD:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                status_next = olpd_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.cmd        = olpd_pkg::CMD_PUSH;
                                held_count_next = held_count_reg + 1'b1;
                                status_next     = olpd_pkg::ST_ADDED;
                            end
                        end
                        olpd_pkg::OP_DELETE:
                        begin
                            out_valid_next = 1'b1;
                            ctrl.cmd       = olpd_pkg::CMD_DELETE;
                            if (hit_any)
                            begin
                                held_count_next = held_count_reg - 1'b1;
                                status_next     = olpd_pkg::ST_REMOVED;
                            end
                            else
                            begin
                                status_next = olpd_pkg::ST_NOT_FOUND;
                            end
                        end
                        olpd_pkg::OP_LIST:
                        begin
                            if (held_count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = olpd_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next  = S_LIST;
                                remain_next = held_count_reg;
                            end
                        end
                        default:
                        begin
                            // no operation, no result
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    ctrl.cmd          = olpd_pkg::CMD_ROTATE;
                    out_valid_next    = 1'b1;
                    result_value_next = value_w[0];
                    status_next       = olpd_pkg::ST_LISTED;
                    last_next         = (remain_reg == CW'(1));
                    remain_next       = remain_reg - 1'b1;
                    if (remain_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        entry_count_next = count_ext[olpd_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            held_count_reg   <= '0;
            remain_reg       <= '0;
            out_valid_reg    <= 1'b0;
            result_value_reg <= '0;
            status_reg       <= '0;
            entry_count_reg  <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            held_count_reg   <= held_count_next;
            remain_reg       <= remain_next;
            out_valid_reg    <= out_valid_next;
            result_value_reg <= result_value_next;
            status_reg       <= status_next;
            entry_count_reg  <= entry_count_next;
            last_reg         <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;
    assign entry_count  = entry_count_reg;
    assign last_of_run  = last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // occupied cells always match the entry count
    a_count_matches_cells : assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(held_count_reg))
        else $error("cell valid bits disagree with entry count");

    // occupied cells are packed at the front of the chain
    a_front_packed : assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("gap in occupied cells");

    // a list run never outlasts the entries held
    a_remain_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> (remain_reg != '0) && (remain_reg <= held_count_reg))
        else $error("list run counter out of range");

    // an accepted add on a list with room grows it by one
    a_add_grows : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (operation == olpd_pkg::OP_ADD) && !full)
            |=> (held_count_reg == $past(held_count_reg) + 1'b1))
        else $error("add did not grow the list");

endmodule

`default_nettype wire

// ===== sim/ordered_list_push_front_delete_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_push_front_delete_tb
// Self-checking bench for the push-front / delete-first-match list. A
// scoreboard keeps its own copy of the list and turns every accepted item
// into the results it should cause. Each returned result is compared with
// the oldest one waiting. Directed cases come first, then random traffic in
// phases that fill and empty the list, with random idle bursts on both sides.
// ----------------------------------------------------------------------------

module ordered_list_push_front_delete_tb;

    localparam int DEPTH       = 16;
    localparam int RAND_ITEMS  = 320;
    localparam int QUIET_ITEMS = 60;

    // code 3 is accepted by the block but does nothing
    localparam logic [olpd_pkg::OP_W-1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic signed [olpd_pkg::VALUE_W-1:0] value;
        logic [olpd_pkg::STATUS_W-1:0]       status;
        logic [olpd_pkg::COUNT_W-1:0]        count;
        logic                                last;
    } list_result_t;

    class list_scoreboard;
        logic signed [olpd_pkg::VALUE_W-1:0] slots [DEPTH];
        int unsigned                         held;
        list_result_t                        pending [$];
        int unsigned                         errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function void push_result(logic signed [olpd_pkg::VALUE_W-1:0] v,
                                  logic [olpd_pkg::STATUS_W-1:0] st, logic last);
            list_result_t r;
            r.value  = v;
            r.status = st;
            r.count  = held[olpd_pkg::COUNT_W-1:0];
            r.last   = last;
            pending.push_back(r);
        endfunction

        // update the list for one accepted item and queue what it causes
        function void note_item(logic [olpd_pkg::OP_W-1:0] op,
                                logic signed [olpd_pkg::VALUE_W-1:0] v);
            int hit;
            hit = -1;
            case (op)
                olpd_pkg::OP_ADD:
                begin
                    if (held >= DEPTH)
                    begin
                        push_result('0, olpd_pkg::ST_FULL, 1'b1);
                    end
                    else
                    begin
                        for (int i = held; i > 0; i--)
                            slots[i] = slots[i-1];
                        slots[0] = v;
                        held++;
                        push_result('0, olpd_pkg::ST_ADDED, 1'b1);
                    end
                end
                olpd_pkg::OP_DELETE:
                begin
                    for (int i = 0; i < held; i++)
                        if (hit < 0 && slots[i] == v)
                            hit = i;
                    if (hit < 0)
                    begin
                        push_result('0, olpd_pkg::ST_NOT_FOUND, 1'b1);
                    end
                    else
                    begin
                        for (int j = hit; j + 1 < held; j++)
                            slots[j] = slots[j+1];
                        held--;
                        push_result('0, olpd_pkg::ST_REMOVED, 1'b1);
                    end
                end
                olpd_pkg::OP_LIST:
                begin
                    if (held == 0)
                        push_result('0, olpd_pkg::ST_EMPTY, 1'b1);
                    else
                        for (int i = 0; i < held; i++)
                            push_result(slots[i], olpd_pkg::ST_LISTED, i + 1 == held);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(logic signed [olpd_pkg::VALUE_W-1:0] v,
                                   logic [olpd_pkg::STATUS_W-1:0] st,
                                   logic [olpd_pkg::COUNT_W-1:0] cnt, logic last);
            list_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result: value %0d status %0d count %0d last %0b",
                         $time, v, st, cnt, last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (v !== want.value)
            begin
                $display("%0t: result_value expected %0d actual %0d", $time, want.value, v);
                errors++;
            end
            if (st !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
                errors++;
            end
            if (cnt !== want.count)
            begin
                $display("%0t: entry_count expected %0d actual %0d", $time, want.count, cnt);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_of_run expected %0b actual %0b", $time, want.last, last);
                errors++;
            end
        endfunction

        // a value currently in the list, so deletes mostly hit
        function logic signed [olpd_pkg::VALUE_W-1:0] pick_held(
            logic signed [olpd_pkg::VALUE_W-1:0] fallback);
            if (held == 0)
                return fallback;
            return slots[$urandom_range(0, held - 1)];
        endfunction
    endclass

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                in_valid     = 1'b0;
    logic                                in_ready;
    logic [olpd_pkg::OP_W-1:0]           operation    = '0;
    logic signed [olpd_pkg::VALUE_W-1:0] item_value   = '0;
    logic                                out_valid;
    logic                                out_ready    = 1'b0;
    logic signed [olpd_pkg::VALUE_W-1:0] result_value;
    logic [olpd_pkg::STATUS_W-1:0]       status;
    logic [olpd_pkg::COUNT_W-1:0]        entry_count;
    logic                                last_of_run;

    bit             idle_on = 1'b1;
    list_scoreboard sb      = new();

    ordered_list_push_front_delete #(
        .LIST_DEPTH (DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .item_value   (item_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (status),
        .entry_count  (entry_count),
        .last_of_run  (last_of_run)
    );

    always #6 clk = ~clk;

    // small pool for duplicates, the extremes, and full-range values
    function automatic logic signed [olpd_pkg::VALUE_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $signed($urandom_range(0, 6)) - 3;
        if (r < 50)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $signed($urandom());
    endfunction

    task automatic send_item(input logic [olpd_pkg::OP_W-1:0] op,
                             input logic signed [olpd_pkg::VALUE_W-1:0] v);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        item_value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(op, v);
    endtask

    // hold off the sender until every queued result is back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(result_value, status, entry_count, last_of_run);
    end

    // receiver: random stall bursts while idling is on
    initial
    begin
        int len;
        wait (rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                len = $urandom_range(1, 15);
                repeat (len) @(posedge clk);
            end
            out_ready <= 1'b1;
            len = $urandom_range(1, 20);
            repeat (len) @(posedge clk);
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int pick;
        int add_pct;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: list, delete with no match, the no-op code
        send_item(olpd_pkg::OP_LIST, 32'sd0);
        send_item(olpd_pkg::OP_DELETE, 32'sd5);
        send_item(OP_NOP, 32'sd9);
        send_item(olpd_pkg::OP_ADD, 32'sh8000_0000);
        send_item(olpd_pkg::OP_ADD, 32'sh7fff_ffff);
        send_item(olpd_pkg::OP_ADD, -32'sd1);
        send_item(olpd_pkg::OP_ADD, -32'sd1);
        send_item(olpd_pkg::OP_LIST, 32'sh7fff_ffff);
        // duplicate: only the front copy goes
        send_item(olpd_pkg::OP_DELETE, -32'sd1);
        send_item(olpd_pkg::OP_DELETE, 32'sh8000_0000);
        // fill up, then overflow, list a full chain, delete from the back
        for (int i = 0; i < DEPTH - 2; i++)
            send_item(olpd_pkg::OP_ADD, rand_value());
        send_item(olpd_pkg::OP_ADD, 32'sd42);
        send_item(olpd_pkg::OP_LIST, 32'sd0);
        send_item(olpd_pkg::OP_DELETE, 32'sh7fff_ffff);
        wait_for_drain();

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == RAND_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            if (n == RAND_ITEMS / 2)
                wait_for_drain();
            case ((n / 40) % 4)
                0:       add_pct = 70;
                1:       add_pct = 25;
                2:       add_pct = 50;
                default: add_pct = 85;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_item(OP_NOP, rand_value());
            else if (pick < 18)
                send_item(olpd_pkg::OP_LIST, rand_value());
            else if (pick < 18 + add_pct * 82 / 100)
                send_item(olpd_pkg::OP_ADD, rand_value());
            else if ($urandom_range(0, 3) != 0)
                send_item(olpd_pkg::OP_DELETE, sb.pick_held(rand_value()));
            else
                send_item(olpd_pkg::OP_DELETE, rand_value());
        end

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/olpd_pkg.sv
rtl/olpd_cell.sv
rtl/ordered_list_push_front_delete.sv
sim/ordered_list_push_front_delete_tb.sv
